>>> hdl/bdlp_pkg.sv
// Shared types and constants for the button debounce and long-press detector.
`default_nettype none
package bdlp_pkg;

  localparam int NOW_BITS      = 32;
  localparam int THR_BITS      = 16;
  localparam int MASK_BITS     = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [THR_BITS-1:0]  DEBOUNCE_RST = 16'd20;
  localparam logic [THR_BITS-1:0]  LONG_RST     = 16'd1000;
  localparam logic [MASK_BITS-1:0] MASK_RST     = 5'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE    = 2'd2;

  localparam int PM_DOWN   = 0;
  localparam int PM_UP     = 1;
  localparam int PM_CLICK  = 2;
  localparam int PM_LSTART = 3;
  localparam int PM_LEND   = 4;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  typedef struct packed {
    logic                raw_level;
    logic [NOW_BITS-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic       ev_down;
    logic       ev_up;
    logic       ev_click;
    logic       ev_long_start;
    logic       ev_long_end;
    logic       is_held;
    logic [1:0] phase_now;
  } out_t;

  typedef struct packed {
    logic [THR_BITS-1:0]  debounce_ms;
    logic [THR_BITS-1:0]  long_press_ms;
    logic [MASK_BITS-1:0] ev_mute;
  } cfg_t;

endpackage
`default_nettype wire

>>> hdl/bdlp_in_stage.sv
// Input register stage: holds one accepted poll until the phase logic takes it.
`default_nettype none
module bdlp_in_stage
  import bdlp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      s_valid,
  input  wire logic s_take,
  output in_t       s_data
);

  logic valid_r, valid_nxt;
  in_t  data_r;

  assign in_ready  = !valid_r || s_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign s_valid = valid_r;
  assign s_data  = data_r;

endmodule
`default_nettype wire

>>> hdl/bdlp_fsm.sv
// Phase machine: elapsed time, threshold compares, phase and mark update, event gating.
`default_nettype none
module bdlp_fsm
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  output out_t      res
);

  localparam int NB = (TIME_BITS < NOW_BITS) ? TIME_BITS : NOW_BITS;

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] mark_r, mark_nxt;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] elapsed;
  logic                 pressed;
  logic                 deb_done;
  logic                 long_done;
  out_t                 res_c;

  assign now_w     = TIME_BITS'(item.now_ms[NB-1:0]);
  assign elapsed   = now_w - mark_r;
  assign pressed   = !item.raw_level;
  assign deb_done  = elapsed >= TIME_BITS'(cfg.debounce_ms);
  assign long_done = elapsed >= TIME_BITS'(cfg.long_press_ms);

  always_comb begin
    phase_nxt = phase_r;
    mark_nxt  = mark_r;
    res_c     = '0;
    case (phase_r)
      PH_IDLE: begin
        if (pressed) begin
          phase_nxt = PH_DEBOUNCE;
          mark_nxt  = now_w;
        end
      end
      PH_DEBOUNCE: begin
        if (!pressed) begin
          phase_nxt = PH_IDLE;
        end else if (deb_done) begin
          phase_nxt     = PH_PRESSED;
          mark_nxt      = now_w;
          res_c.ev_down = !cfg.ev_mute[PM_DOWN];
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          phase_nxt      = PH_IDLE;
          res_c.ev_up    = !cfg.ev_mute[PM_UP];
          res_c.ev_click = !cfg.ev_mute[PM_CLICK];
        end else if (long_done) begin
          phase_nxt           = PH_LONG;
          res_c.ev_long_start = !cfg.ev_mute[PM_LSTART];
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_nxt         = PH_IDLE;
          res_c.ev_up       = !cfg.ev_mute[PM_UP];
          res_c.ev_long_end = !cfg.ev_mute[PM_LEND];
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    res_c.is_held   = (phase_nxt == PH_PRESSED) || (phase_nxt == PH_LONG);
    res_c.phase_now = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mark_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mark_r  <= mark_nxt;
    end
  end

  assign res = res_c;

endmodule
`default_nettype wire

>>> hdl/button_debounce_long_press.sv
// Top level: configuration registers, input stage, phase machine and result register.
`default_nettype none
// One poll (raw active-low level plus millisecond timestamp) is taken per clock cycle
// while out_ready does not hold back the result register; its result beat is offered
// from the result register once the phase logic has taken the poll from the input
// register. Polls pass through an input register, one pass of the phase logic (a
// TIME_BITS-wide subtract and two compares against the 16-bit thresholds) and a result
// register. Each poll yields exactly one result beat. Configuration writes act at once
// and are meant to be made while no poll is in flight.
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic s_valid;
  logic s_take;
  in_t  s_data;
  out_t res;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.long_press_ms <= LONG_RST;
      cfg_r.ev_mute       <= MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce_ms   <= cfg_wdata[THR_BITS-1:0];
        CFG_LONG:     cfg_r.long_press_ms <= cfg_wdata[THR_BITS-1:0];
        CFG_PAUSE:    cfg_r.ev_mute       <= cfg_wdata[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  bdlp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_take   (s_take),
    .s_data   (s_data)
  );

  bdlp_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s_take),
    .item  (s_data),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign s_take        = s_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = s_take || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_held_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_held ==
      ((out_data.phase_now == PH_PRESSED) || (out_data.phase_now == PH_LONG))))
    else $error("is_held disagrees with phase_now");

  a_release_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.ev_up || out_data.ev_click || out_data.ev_long_end))
      |-> (out_data.phase_now == PH_IDLE))
    else $error("release event without return to idle");

  a_one_transition: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.ev_down, out_data.ev_long_start,
                            out_data.ev_click, out_data.ev_long_end}))
    else $error("more than one transition event in a beat");

  a_take_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s_take |=> out_valid)
    else $error("processed poll produced no result beat");

endmodule
`default_nettype wire
